[hw/rtl/bta_pkg.sv]
// bta_pkg: shared constants and types for the buddy tree allocator.
// No dependencies.
`default_nettype none
package bta_pkg;
  localparam int unsigned LevelsDefault = 12;
  localparam logic [31:0] PoolReset = 32'd10485760;
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;
  // one tree node's flags
  typedef struct packed {
    logic alloc;
    logic lbusy;
    logic rbusy;
  } node_t;
endpackage
`default_nettype wire

[hw/rtl/buddy_tree_allocator_core.sv]
// buddy_tree_allocator_core: top level, sequencer over the node flag memory.
// Depends on bta_pkg and bta_mem.
//
//  channel | direction | handshake      | payload
//  in      | input     | valid / stall  | action, request_bytes, free_address
//  out     | output    | valid / stall  | grant_address, granted
//  cfg     | input     | valid / ready  | pool_bytes write data
//
// Reset clears flags with a sweep over all 2^LEVELS entries; no transaction is
// taken until it ends. Each node visit steps through address, read and decide
// on the way down and through step to parent, address, read and decide on the
// way back up, all on the single memory read port. The result register holds
// while out is stalled; a new transaction is taken only once the previous
// result has left.
`default_nettype none
module buddy_tree_allocator_core import bta_pkg::*; #(
  parameter int unsigned LEVELS = LevelsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [31:0] request_bytes_i,
  input  wire logic [31:0] free_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      grant_address_o,
  output logic             granted_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned AW = LEVELS;
  localparam int unsigned DW = $clog2(LEVELS + 1);
  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SRd = 4'd2, SWait = 4'd3,
                         SDec = 4'd4, SUp = 4'd5, SUpRd = 4'd6, SUpWt = 4'd7,
                         SUpDec = 4'd8;

  logic [3:0]    st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   pool_q;
  logic          act_q;
  logic [31:0]   req_q, addr_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [DW-1:0] dep_q, dep_d;
  logic [32:0]   off_q, off_d;
  logic          rel_q, rel_d;   // child reported release (free) or grant (allocate) upward
  logic          rel_idx_right_q; // the child just returned from is a right child
  logic          ov_q, ov_d, og_q, og_d;
  logic [31:0]   oa_q, oa_d;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  node_t         wdata, rd;

  bta_mem #(.AW(AW)) u_mem (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd));

  assign cfg_ready_o = (st_q == SIdle);
  assign in_stall_o  = !(st_q == SIdle && !ov_q);
  assign out_valid_o = ov_q;
  assign grant_address_o = oa_q;
  assign granted_o = og_q;

  logic [31:0] sz, half;
  logic        leaf, isright, isroot;
  logic [AW-1:0] par;
  assign sz   = pool_q >> dep_q;
  assign half = sz >> 1;
  assign leaf = (32'(dep_q) + 32'd1 >= 32'(LEVELS));
  assign isroot = (idx_q == '0);
  assign isright = !idx_q[0] && !isroot;
  assign par = (idx_q - AW'(1)) >> 1;
  logic [32:0] psz;
  assign psz = {1'b0, pool_q >> (dep_q - DW'(1))} >> 1;

  always_comb begin
    st_d = st_q; clr_d = clr_q; idx_d = idx_q; dep_d = dep_q; off_d = off_q;
    rel_d = rel_q; ov_d = ov_q; og_d = og_q; oa_d = oa_q;
    we = 1'b0; waddr = idx_q; wdata = rd; raddr = idx_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      SClr: begin
        we = 1'b1; waddr = clr_q; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) st_d = SIdle;
      end
      SIdle: if (in_valid_i && !in_stall_o) begin
        idx_d = '0; dep_d = '0; off_d = '0; st_d = SRd;
      end
      SRd: st_d = SWait;
      SWait: st_d = SDec;
      SDec: begin
        // visit node idx_q with fresh flags in rd
        st_d = SRd;
        if (act_q == ActAlloc) begin
          if (req_q > sz || rd.alloc) begin
            rel_d = 1'b0; st_d = SUp;          // fail, backtrack
          end else if (req_q <= half && !leaf) begin
            idx_d = {idx_q[AW-2:0], 1'b0} + AW'(1); dep_d = dep_q + 1'b1;
          end else if (leaf || (!rd.lbusy && !rd.rbusy)) begin
            we = 1'b1; wdata = rd; wdata.alloc = 1'b1;
            rel_d = 1'b1; oa_d = off_q[31:0]; st_d = SUp;
          end else begin
            rel_d = 1'b0; st_d = SUp;
          end
        end else begin
          if ({1'b0, addr_q} < off_q || (!rd.lbusy && !rd.rbusy && !rd.alloc)) begin
            rel_d = 1'b0; st_d = SUp;
          end else if ({1'b0, addr_q} == off_q && rd.alloc) begin
            we = 1'b1; wdata = rd; wdata.alloc = 1'b0; rel_d = 1'b1; st_d = SUp;
          end else if (leaf) begin
            rel_d = 1'b0; st_d = SUp;
          end else if ({1'b0, addr_q} >= off_q + {1'b0, half}) begin
            idx_d = {idx_q[AW-2:0], 1'b0} + AW'(2); dep_d = dep_q + 1'b1;
            off_d = off_q + {1'b0, half};
          end else begin
            idx_d = {idx_q[AW-2:0], 1'b0} + AW'(1); dep_d = dep_q + 1'b1;
          end
        end
      end
      SUp: begin
        // return from idx_q to its parent with outcome rel_q
        if (isroot) begin
          if (act_q == ActAlloc) begin
            ov_d = 1'b1; og_d = rel_q; if (!rel_q) oa_d = '0;
          end
          st_d = SIdle;
        end else begin
          if (isright) off_d = off_q - psz;
          idx_d = par; dep_d = dep_q - 1'b1; st_d = SUpRd;
        end
      end
      SUpRd: st_d = SUpWt;
      SUpWt: st_d = SUpDec;
      SUpDec: begin
        // idx_q is the parent; rel_idx_right_q tells which side the child came from
        st_d = SUp;
        if (act_q == ActAlloc) begin
          if (rel_q) begin
            we = 1'b1; wdata = rd;
            if (rel_idx_right_q) wdata.rbusy = 1'b1; else wdata.lbusy = 1'b1;
          end else if (!rel_idx_right_q) begin
            idx_d = {idx_q[AW-2:0], 1'b0} + AW'(2); dep_d = dep_q + 1'b1;
            off_d = off_q + {1'b0, half}; st_d = SRd;
          end
        end else if (rel_q) begin
          we = 1'b1; wdata = rd;
          if (rel_idx_right_q) begin
            wdata.rbusy = 1'b0; rel_d = !rd.lbusy;
          end else begin
            wdata.lbusy = 1'b0; rel_d = !rd.rbusy;
          end
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; clr_q <= '0; pool_q <= PoolReset; ov_q <= 1'b0;
      rel_idx_right_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; ov_q <= ov_d;
      if (cfg_valid_i && cfg_ready_o) pool_q <= cfg_data_i;
      if (st_q == SUp) rel_idx_right_q <= isright;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_valid_i && !in_stall_o) begin
      act_q <= action_i; req_q <= request_bytes_i; addr_q <= free_address_i;
    end
    idx_q <= idx_d; dep_q <= dep_d; off_q <= off_d; rel_q <= rel_d;
    og_q <= og_d; oa_q <= oa_d;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> in_stall_o) else $error("accept while busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (grant_address_o == '0)) else $error("bad fail addr");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o || st_q == SIdle) else $error("cfg while busy");
`endif
endmodule
`default_nettype wire

[hw/rtl/bta_mem.sv]
// bta_mem: node flag memory, one write and one registered read port.
// Depends on bta_pkg.
`default_nettype none
module bta_mem import bta_pkg::*; #(
  parameter int unsigned AW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire node_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output node_t              rdata_o
);
  node_t mem_q [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
